/* rtl/core/rlde_pkg.sv */
// Shared types and constants of the run-length decimal encoder.
`default_nettype none
package rlde_pkg;

  localparam int COUNT_BITS = 16;

  // Decimal digits needed for the largest run count.
  function automatic int dec_digits(input int bits);
    logic [63:0] v;
    int n;
    begin
      v = (64'd1 << bits) - 64'd1;
      n = 0;
      for (int i = 0; i < 20; i++) begin
        if (v != 64'd0) begin
          v = v / 64'd10;
          n++;
        end
      end
      return n;
    end
  endfunction

  localparam int NDIG    = dec_digits(COUNT_BITS);
  localparam int BCD_W   = 4 * NDIG;
  localparam int NDIG_W  = $clog2(NDIG + 1);
  localparam int DIDX_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int POS_W   = $clog2(NDIG + 3);
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
  localparam int TOT_W   = 16;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // One finished run to be written out, with an optional single-byte run after it.
  typedef struct packed {
    logic [7:0]       run_byte;
    logic             multi;      // run longer than one: digits follow
    logic [BCD_W-1:0] run_bcd;
    logic             has_tail;
    logic [7:0]       tail_byte;
    logic             last;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/core/rlde_front.sv */
// Front end: run tracking in binary and BCD, issues flush commands.
`default_nettype none
module rlde_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic                 stall,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  output logic                      enq,
  output rlde_pkg::cmd_t            cmd
);
  import rlde_pkg::*;

  localparam logic [COUNT_BITS-1:0] LEN_MAX = '1;
  localparam logic [BCD_W-1:0]      BCD_ONE = BCD_W'(1);
  localparam logic [COUNT_BITS-1:0] LEN_ONE = COUNT_BITS'(1);

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             c;
    begin
      c = 1'b1;
      r = v;
      for (int i = 0; i < NDIG; i++) begin
        if (c) begin
          if (v[i*4 +: 4] == 4'd9) begin
            r[i*4 +: 4] = 4'd0;
          end else begin
            r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
            c = 1'b0;
          end
        end
      end
      return r;
    end
  endfunction

  logic [7:0]            run_byte, run_byte_next;
  logic [COUNT_BITS-1:0] run_length, run_length_next;
  logic [BCD_W-1:0]      run_bcd, run_bcd_next;
  logic                  run_open, run_open_next;
  logic                  accept;
  logic                  sat;
  logic [COUNT_BITS-1:0] len_inc;
  logic [BCD_W-1:0]      bcd_up;

  assign accept  = push & ~stall;
  assign sat     = (run_length == LEN_MAX);
  assign len_inc = sat ? run_length : run_length + LEN_ONE;
  assign bcd_up  = sat ? run_bcd : bcd_inc(run_bcd);

  always_comb begin
    run_byte_next   = run_byte;
    run_length_next = run_length;
    run_bcd_next    = run_bcd;
    run_open_next   = run_open;
    enq             = 1'b0;
    cmd.run_byte    = run_byte;
    cmd.multi       = (run_length != LEN_ONE);
    cmd.run_bcd     = run_bcd;
    cmd.has_tail    = 1'b0;
    cmd.tail_byte   = in_byte;
    cmd.last        = in_last;
    if (accept) begin
      priority if (!run_open) begin
        run_byte_next   = in_byte;
        run_length_next = LEN_ONE;
        run_bcd_next    = BCD_ONE;
        run_open_next   = 1'b1;
        enq             = in_last;
        cmd.run_byte    = in_byte;
        cmd.multi       = 1'b0;
        cmd.run_bcd     = BCD_ONE;
      end else if (in_byte == run_byte) begin
        run_length_next = len_inc;
        run_bcd_next    = bcd_up;
        enq             = in_last;
        cmd.multi       = (len_inc != LEN_ONE);
        cmd.run_bcd     = bcd_up;
      end else begin
        // previous run ends; a final new byte rides along as a one-byte run
        run_byte_next   = in_byte;
        run_length_next = LEN_ONE;
        run_bcd_next    = BCD_ONE;
        enq             = 1'b1;
        cmd.has_tail    = in_last;
      end
      if (in_last) begin
        run_byte_next   = '0;
        run_length_next = '0;
        run_bcd_next    = '0;
        run_open_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte   <= '0;
      run_length <= '0;
      run_bcd    <= '0;
      run_open   <= 1'b0;
    end else begin
      run_byte   <= run_byte_next;
      run_length <= run_length_next;
      run_bcd    <= run_bcd_next;
      run_open   <= run_open_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rlde_queue.sv */
// Short command queue between front and back.
`default_nettype none
module rlde_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           enq,
  input  rlde_pkg::cmd_t      enq_cmd,
  input  wire logic           deq,
  output logic                full,
  output logic                empty,
  output rlde_pkg::cmd_t      head
);
  import rlde_pkg::*;

  cmd_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_enq, do_deq;

  assign full   = (count == QCNT_W'(Q_DEPTH));
  assign empty  = (count == '0);
  assign do_enq = enq & ~full;
  assign do_deq = deq & ~empty;
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_deq) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_enq, do_deq})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rlde_back.sv */
// Back end: walks each command out as run byte, decimal digits and tail byte.
`default_nettype none
module rlde_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  rlde_pkg::cmd_t      head,
  output logic                deq,
  input  wire logic           pop,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [15:0]         compressed_length
);
  import rlde_pkg::*;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  logic [POS_W-1:0]  pos;
  logic [NDIG_W-1:0] nd;
  logic [POS_W-1:0]  n_words;
  logic [POS_W-1:0]  didx_full;
  logic [DIDX_W-1:0] didx;
  logic [3:0]        digit;
  logic              take;
  logic              end_of_cmd;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_inc;

  // significant decimal digits of the run count
  always_comb begin
    nd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (head.run_bcd[i*4 +: 4] != 4'd0) begin
        nd = NDIG_W'(i + 1);
      end
    end
  end

  assign n_words = POS_W'(1) + (head.multi ? POS_W'(nd) : '0) + POS_W'(head.has_tail);
  assign didx_full = POS_W'(nd) - pos;
  assign didx = didx_full[DIDX_W-1:0];

  always_comb begin
    digit = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (didx == DIDX_W'(i)) begin
        digit = head.run_bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    priority if (pos == '0) begin
      out_byte = head.run_byte;
    end else if (head.multi && (pos <= POS_W'(nd))) begin
      out_byte = ASCII_ZERO | {4'd0, digit};
    end else begin
      out_byte = head.tail_byte;
    end
  end

  assign end_of_cmd = (pos == n_words - POS_W'(1));
  assign take       = pop & ~q_empty;
  assign deq        = take & end_of_cmd;
  assign out_last   = head.last & end_of_cmd;
  assign total_inc  = (total == TOT_MAX) ? total : total + TOT_W'(1);
  assign compressed_length = out_last ? total_inc : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      total <= '0;
    end else if (take) begin
      pos   <= end_of_cmd ? '0 : pos + POS_W'(1);
      total <= out_last ? '0 : total_inc;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/run_length_decimal_encoder.sv */
// Run-length encoder with decimal counts: top level.
// Takes one message byte per cycle (in_last on the final byte) and, while pop
// is high and a command is queued, gives one compressed word per cycle: each
// run's byte, then its length as ASCII decimal digits, most significant first,
// when the run is longer than one. Counts saturate at 2^16-1. The final word
// carries out_last and the message's total word count in compressed_length
// (saturating at 65535). The front keeps the run count in binary and BCD side
// by side, so no division is needed; finished runs go through a four-entry
// command queue to the back, which emits one word per cycle on pop. Input is
// taken every cycle unless that queue is full.
`default_nettype none
module run_length_decimal_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [15:0]      compressed_length
);
  import rlde_pkg::*;

  logic enq;
  logic deq;
  cmd_t cmd;
  cmd_t head;

  rlde_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .stall   (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .enq     (enq),
    .cmd     (cmd)
  );

  rlde_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (cmd),
    .deq     (deq),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  rlde_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (empty),
    .head              (head),
    .deq               (deq),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .compressed_length (compressed_length)
  );

endmodule
`default_nettype wire
